@@ src/fbfa_pkg.sv @@
`default_nettype none

package fbfa_pkg;

   localparam int unsigned BLOCK_COUNT = 1024;
   localparam int unsigned BLOCK_BYTES = 64;

   localparam int unsigned IDX_W  = 10;
   localparam int unsigned OFS_W  = 16;
   localparam int unsigned ADDR_W = $clog2(BLOCK_COUNT);
   localparam int unsigned LINK_W = $clog2(BLOCK_COUNT + 1);

   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned RSP_DATA_W = 32;
   localparam int unsigned RSP_PAD_W  = RSP_DATA_W - (3 + IDX_W + OFS_W);
   localparam int unsigned REQ_PAD_W  = REQ_DATA_W - IDX_W;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } fbfa_op_type;

   typedef enum logic [1:0] {
      ST_INIT,
      ST_IDLE,
      ST_POP
   } fbfa_state_type;

   typedef enum logic [1:0] {
      RES_GRANT,
      RES_EMPTY,
      RES_BAD,
      RES_FREED
   } fbfa_res_sel_type;

   typedef struct packed {
      logic             init_step;
      logic             pop_read;
      logic             pop_finish;
      logic             push;
      logic             post;
      fbfa_res_sel_type res_sel;
   } fbfa_cmd_type;

   typedef struct packed {
      logic init_last;
      logic head_empty;
      logic bad_index;
      logic res_open;
   } fbfa_sts_type;

   typedef struct packed {
      logic              bad_free;
      logic              pool_empty;
      logic [OFS_W-1:0]  byte_offset;
      logic [IDX_W-1:0]  alloc_index;
      logic              granted;
   } fbfa_result_type;

endpackage

`default_nettype wire

@@ src/fbfa_ctrl.sv @@
`default_nettype none

module fbfa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tuser,
   output logic                 req_tready,
   input  fbfa_pkg::fbfa_sts_type sts,
   output fbfa_pkg::fbfa_cmd_type cmd
);
   import fbfa_pkg::*;

   fbfa_state_type state_ff;
   fbfa_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      cmd         = '0;
      cmd.res_sel = RES_FREED;
      unique case (state_ff)
         ST_INIT: begin
            cmd.init_step = 1'b1;
            if (sts.init_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = sts.res_open;
            if (req_tvalid && sts.res_open) begin
               if (req_tuser == OP_FREE) begin
                  cmd.post = 1'b1;
                  if (sts.bad_index) begin
                     cmd.res_sel = RES_BAD;
                  end else begin
                     cmd.push    = 1'b1;
                     cmd.res_sel = RES_FREED;
                  end
               end else if (sts.head_empty) begin
                  cmd.post    = 1'b1;
                  cmd.res_sel = RES_EMPTY;
               end else begin
                  // link of the head block comes back next cycle
                  cmd.pop_read = 1'b1;
                  state_in     = ST_POP;
               end
            end
         end
         ST_POP: begin
            cmd.pop_finish = 1'b1;
            cmd.post       = 1'b1;
            cmd.res_sel    = RES_GRANT;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> (state_ff == ST_IDLE))
      else $error("transfer taken outside idle");

   a_pop_pair: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_read |=> cmd.pop_finish)
      else $error("pop read not followed by pop finish");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_read |-> !sts.head_empty)
      else $error("pop issued on empty list");

endmodule

`default_nettype wire

@@ src/fbfa_datapath.sv @@
`default_nettype none

module fbfa_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [fbfa_pkg::IDX_W-1:0]         req_idx,
   input  fbfa_pkg::fbfa_cmd_type             cmd,
   output fbfa_pkg::fbfa_sts_type             sts,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output fbfa_pkg::fbfa_result_type          rsp_result
);
   import fbfa_pkg::*;

   logic [LINK_W-1:0] link_mem [BLOCK_COUNT];

   logic [LINK_W-1:0] head_ff;
   logic [LINK_W-1:0] head_in;
   logic [ADDR_W-1:0] init_cnt_ff;
   logic [ADDR_W-1:0] init_cnt_in;
   logic [LINK_W-1:0] rd_data_ff;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [LINK_W-1:0] wr_data;
   logic [ADDR_W-1:0] rd_addr;

   fbfa_result_type   res_ff;
   fbfa_result_type   res_in;
   logic              res_valid_ff;
   logic              res_valid_in;
   fbfa_result_type   out_ff;
   logic              out_valid_ff;
   logic              out_valid_in;
   logic              res_move;
   logic [31:0]       ofs_full;

   assign sts.init_last  = (init_cnt_ff == ADDR_W'(BLOCK_COUNT - 1));
   assign sts.head_empty = (head_ff >= LINK_W'(BLOCK_COUNT));
   assign sts.bad_index  = (32'(req_idx) >= BLOCK_COUNT);

   // buffer slot frees up when its result moves into the output register
   assign res_move     = res_valid_ff && (!out_valid_ff || rsp_ready);
   assign sts.res_open = !res_valid_ff || res_move;

   // link memory: one write port shared by the init sweep and frees
   always_comb begin
      wr_en   = cmd.init_step || cmd.push;
      wr_addr = cmd.init_step ? init_cnt_ff : ADDR_W'(req_idx);
      wr_data = cmd.init_step ? (LINK_W'(init_cnt_ff) + LINK_W'(1)) : head_ff;
      rd_addr = ADDR_W'(head_ff);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= link_mem[rd_addr];
   end

   always_comb begin
      init_cnt_in = cmd.init_step ? (init_cnt_ff + ADDR_W'(1)) : init_cnt_ff;
      head_in     = head_ff;
      if (cmd.pop_finish) begin
         head_in = rd_data_ff;
      end else if (cmd.push) begin
         head_in = LINK_W'(req_idx);
      end
   end

   assign ofs_full = 32'(head_ff) * 32'(BLOCK_BYTES);

   always_comb begin
      res_in = '0;
      case (cmd.res_sel)
         RES_GRANT: begin
            res_in.granted     = 1'b1;
            res_in.alloc_index = IDX_W'(head_ff);
            res_in.byte_offset = ofs_full[OFS_W-1:0];
         end
         RES_EMPTY: res_in.pool_empty = 1'b1;
         RES_BAD:   res_in.bad_free   = 1'b1;
         default:   res_in = '0;
      endcase
      res_valid_in = cmd.post || (res_valid_ff && !res_move);
      out_valid_in = res_move || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         init_cnt_ff  <= '0;
         res_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         init_cnt_ff  <= init_cnt_in;
         res_valid_ff <= res_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.post) begin
         res_ff <= res_in;
      end
      if (res_move) begin
         out_ff <= res_ff;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_result = out_ff;

   a_post_room: assert property (@(posedge clock) disable iff (reset)
      cmd.post |-> sts.res_open)
      else $error("result posted into a full buffer");

   a_push_head: assert property (@(posedge clock) disable iff (reset)
      cmd.push |=> !sts.head_empty)
      else $error("head out of range after free");

   a_init_quiet: assert property (@(posedge clock) disable iff (reset)
      cmd.init_step |-> !(cmd.post || cmd.push || cmd.pop_read))
      else $error("item work during init sweep");

endmodule

`default_nettype wire

@@ src/fixed_block_free_list_allocator_unit.sv @@
// channel  dir  signals                            payload
// req      in   req_tvalid/req_tready/tdata/tuser  tuser: operation; tdata: block_index
// rsp      out  rsp_tvalid/rsp_tready/tdata        granted, alloc_index, byte_offset,
//                                                  pool_empty, bad_free
//
// free and failed allocate finish in ST_IDLE; a granted allocate also passes through ST_POP
// because the head's link is read from the synchronous link memory before the head moves.
// results leave through a one-entry buffer and an output register, so one more item
// is taken while a result waits on rsp_tready.
// after reset the link memory is swept once, one entry per cycle, with req_tready low.
`default_nettype none

module fixed_block_free_list_allocator_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [fbfa_pkg::REQ_DATA_W-1:0]     req_tdata,  // block_index, zero pad
   input  logic                                req_tuser,  // operation
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // granted, alloc_index, byte_offset, pool_empty, bad_free, zero pad
   output logic [fbfa_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import fbfa_pkg::*;

   fbfa_cmd_type    cmd;
   fbfa_sts_type    sts;
   fbfa_result_type rsp_result;
   logic [REQ_PAD_W-1:0] req_pad_unused;

   assign req_pad_unused = req_tdata[REQ_DATA_W-1:IDX_W];

   fbfa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   fbfa_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_idx    (req_tdata[IDX_W-1:0]),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (rsp_result)
   );

   assign rsp_tdata = {RSP_PAD_W'(0), rsp_result.bad_free, rsp_result.pool_empty,
                       rsp_result.byte_offset, rsp_result.alloc_index,
                       rsp_result.granted};

endmodule

`default_nettype wire

@@ bench/fixed_block_free_list_allocator_unit_tb.sv @@
`default_nettype none

module fixed_block_free_list_allocator_unit_tb;
   import fbfa_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RESULT_W    = $bits(fbfa_result_type);

   // mirror of the free list: per-block links, head, and the results still owed
   class free_list_tracker;
      logic [LINK_W-1:0] link_mem [BLOCK_COUNT];
      logic [LINK_W-1:0] head;
      fbfa_result_type   owed_results[$];
      int                errors;

      function new();
         for (int i = 0; i < BLOCK_COUNT; i++) begin
            link_mem[i] = LINK_W'(i + 1);
         end
         head   = '0;
         errors = 0;
      endfunction

      function bit pool_is_empty();
         return int'(head) >= BLOCK_COUNT;
      endfunction

      // note an accepted request and work out the result it must produce
      function fbfa_result_type apply_request(fbfa_op_type op, logic [IDX_W-1:0] idx);
         fbfa_result_type res;
         int              blk;
         res = '0;
         if (op == OP_ALLOC) begin
            if (pool_is_empty()) begin
               res.pool_empty = 1'b1;
            end else begin
               blk             = int'(head);
               head            = link_mem[blk];
               res.granted     = 1'b1;
               res.alloc_index = IDX_W'(blk);
               res.byte_offset = OFS_W'(blk * BLOCK_BYTES);
            end
         end else begin
            if (int'(idx) >= BLOCK_COUNT) begin
               res.bad_free = 1'b1;
            end else begin
               link_mem[idx] = head;
               head          = LINK_W'(idx);
            end
         end
         owed_results.push_back(res);
         return res;
      endfunction

      function void flag_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_response(fbfa_result_type got);
         fbfa_result_type want;
         if (owed_results.size() == 0) begin
            $display("%0t: unexpected result %h, expected none", $time, got);
            errors++;
         end else begin
            want = owed_results.pop_front();
            flag_field("granted", 32'(want.granted), 32'(got.granted));
            flag_field("alloc_index", 32'(want.alloc_index), 32'(got.alloc_index));
            flag_field("byte_offset", 32'(want.byte_offset), 32'(got.byte_offset));
            flag_field("pool_empty", 32'(want.pool_empty), 32'(got.pool_empty));
            flag_field("bad_free", 32'(want.bad_free), 32'(got.bad_free));
         end
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   free_list_tracker tracker = new();
   int               held_blocks[$];
   int               send_calm = 0;
   int               recv_calm = 0;
   int               cycle_count = 0;

   fixed_block_free_list_allocator_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("fixed_block_free_list_allocator_unit_tb: errors");
         $finish;
      end
   end

   // mostly a random wait, with occasional runs of back-to-back transfers
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 49) == 0) begin
         calm = $urandom_range(10, 40);
      end
      return $urandom_range(0, 10);
   endfunction

   // called at a falling edge, returns at a falling edge with tvalid still high
   task automatic send_request(input fbfa_op_type op, input logic [IDX_W-1:0] idx,
                               output fbfa_result_type res);
      int gap;
      gap = draw_wait(send_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{REQ_PAD_W{1'b0}}, idx};
      do @(posedge clock); while (!req_tready);
      res = tracker.apply_request(op, idx);
      @(negedge clock);
   endtask

   task automatic grab_block();
      fbfa_result_type res;
      send_request(OP_ALLOC, IDX_W'($urandom_range(0, BLOCK_COUNT - 1)), res);
      if (res.granted) begin
         held_blocks.push_back(int'(res.alloc_index));
      end
   endtask

   task automatic release_block(input int idx);
      fbfa_result_type res;
      int              found[$];
      found = held_blocks.find_first_index(b) with (b == idx);
      if (found.size() != 0) begin
         held_blocks.delete(found[0]);
      end
      send_request(OP_FREE, IDX_W'(idx), res);
   endtask

   task automatic release_any_block();
      int k;
      int idx;
      k   = $urandom_range(0, held_blocks.size() - 1);
      idx = held_blocks[k];
      release_block(idx);
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (tracker.owed_results.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // result side
   initial begin
      fbfa_result_type got;
      int              stall;
      @(negedge clock);
      forever begin
         stall = draw_wait(recv_calm);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got = fbfa_result_type'(rsp_tdata[RESULT_W-1:0]);
         tracker.check_response(got);
         @(negedge clock);
      end
   end

   // request side
   initial begin
      fbfa_result_type res;
      int              alloc_pct;
      int              a;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // a few pops and pushes from the fresh ascending list
      repeat (4) grab_block();
      release_block(2);
      release_block(0);
      repeat (3) grab_block();
      release_block(3);
      release_block(1);
      grab_block();

      // pop everything, then allocate on an empty pool
      while (!tracker.pool_is_empty()) grab_block();
      repeat (3) grab_block();
      wait_for_results();

      // highest and lowest block indices
      release_block(BLOCK_COUNT - 1);
      grab_block();
      release_block(BLOCK_COUNT - 1);
      release_block(0);
      repeat (2) grab_block();

      // well-formed traffic with a drifting allocate/free mix
      alloc_pct = 50;
      for (int n = 0; n < 500; n++) begin
         if (n % 50 == 0) begin
            case ($urandom_range(0, 2))
               0: alloc_pct = 15;
               1: alloc_pct = 50;
               default: alloc_pct = 85;
            endcase
         end
         if (held_blocks.size() == 0 || $urandom_range(0, 99) < alloc_pct) begin
            grab_block();
         end else begin
            release_any_block();
         end
      end
      wait_for_results();

      // noise: frees of arbitrary blocks, which may push a block already on the list
      for (int n = 0; n < 50; n++) begin
         if ($urandom_range(0, 99) < 30) begin
            release_block($urandom_range(0, BLOCK_COUNT - 1));
         end else if (held_blocks.size() == 0 || $urandom_range(0, 1) == 0) begin
            grab_block();
         end else begin
            release_any_block();
         end
      end

      // double free: the block goes on twice and the list turns cyclic
      if (held_blocks.size() == 0) begin
         grab_block();
      end
      a = (held_blocks.size() != 0) ? held_blocks[0] : 5;
      release_block(a);
      send_request(OP_FREE, IDX_W'(a), res);
      repeat (4) grab_block();

      wait_for_results();
      repeat (20) @(posedge clock);
      if (tracker.errors == 0 && tracker.owed_results.size() == 0) begin
         $display("fixed_block_free_list_allocator_unit_tb: clean");
      end else begin
         $display("fixed_block_free_list_allocator_unit_tb: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ files.f @@
src/fbfa_pkg.sv
src/fbfa_ctrl.sv
src/fbfa_datapath.sv
src/fixed_block_free_list_allocator_unit.sv
bench/fixed_block_free_list_allocator_unit_tb.sv
